/* rtl/core/fcm_pkg.sv */
// Shared types, constants and helpers of the flow cache metering block.
package fcm_pkg;

  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned FLAG_FIN_BIT = 0;
  localparam int unsigned FLAG_RST_BIT = 2;

  localparam logic [15:0] ACTIVE_RESET_S = 16'd60;
  localparam logic [15:0] INACTIVE_RESET_S = 16'd10;
  localparam logic [5:0] LIMIT_RESET = 6'd32;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_INACTIVE = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] time_ms;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic [7:0]  proto;
    logic [7:0]  tos_in;
    logic [7:0]  flags_in;
    logic [15:0] pkt_len;
  } item_t;

  typedef struct packed {
    logic [31:0] rec_src_addr;
    logic [31:0] rec_dst_addr;
    logic [15:0] rec_src_port;
    logic [15:0] rec_dst_port;
    logic [7:0]  rec_proto;
    logic [7:0]  rec_tos;
    logic [7:0]  rec_flags;
    logic [31:0] rec_packets;
    logic [31:0] rec_bytes;
    logic [31:0] rec_first_ms;
    logic [31:0] rec_last_ms;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [7:0]  tos;
    logic [7:0]  flags;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [31:0] first_ms;
    logic [31:0] last_ms;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TMO,
    ST_MATCH,
    ST_EVICT,
    ST_APPEND,
    ST_FLUSH,
    ST_DONE
  } state_t;

  function automatic result_t to_result(input entry_t e, input logic last);
    result_t r;
    r.rec_src_addr = e.src_addr;
    r.rec_dst_addr = e.dst_addr;
    r.rec_src_port = e.sport;
    r.rec_dst_port = e.dport;
    r.rec_proto = e.proto;
    r.rec_tos = e.tos;
    r.rec_flags = e.flags;
    r.rec_packets = e.packets;
    r.rec_bytes = e.bytes;
    r.rec_first_ms = e.first_ms;
    r.rec_last_ms = e.last_ms;
    r.last_of_run = last;
    return r;
  endfunction

endpackage

/* rtl/core/fcm_cell.sv */
// One cache cell: holds a flow entry and takes its neighbor's entry on a shift.
module fcm_cell (
  input  logic              clk,
  input  fcm_pkg::cell_ctl_t ctl,
  input  fcm_pkg::entry_t   from_next,
  input  fcm_pkg::entry_t   load_data,
  output fcm_pkg::entry_t   q
);

  // A load into this cell wins over the shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_data;
    end else if (ctl.shift) begin
      q <= from_next;
    end
  end

endmodule

/* rtl/core/flow_cache_metering.sv */
// Top level of the flow cache metering block: controller, cell chain and result port.
//
// The block keeps up to CACHE_DEPTH flows in a chain of cells ordered oldest
// first, cell 0 being the oldest. An item is taken when start is high and busy
// is low. A packet item makes two passes over the chain, one cell a cycle: the
// first pops each entry from cell 0 and either exports it on a timeout or puts
// it back at the tail, the second does the same to find and update a matching
// flow, exporting it on FIN or RST. A miss then evicts the oldest flow if the
// cache has reached its limit and appends the new flow, or exports it at once
// on FIN or RST. The next item can be taken in the first cycle that busy is
// low. Each exported flow comes out as one word on result for exactly one cycle,
// marked by result_valid; the receiver cannot stall it. Each word is held back
// until the next export or the end of the item shows whether it is the last of
// the item, so the last word appears in the first cycle after busy falls and
// last_of_run marks it; an item that exports nothing produces no word.
// Registers are to be written through cfg_valid, cfg_index and cfg_data while
// the block is idle; the block itself does not enforce this. cfg_ready is
// always high. Timeout registers hold seconds and are turned into millisecond
// thresholds when written.
module flow_cache_metering #(
  parameter int unsigned CACHE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fcm_pkg::item_t    item,
  output logic              result_valid,
  output fcm_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);

  fcm_pkg::state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] rem, rem_next;
  logic          found, found_next;
  fcm_pkg::item_t item_r;

  logic [31:0] act_thr;
  logic [31:0] ina_thr;
  logic [5:0]  cache_limit;
  logic [CW-1:0] lim;

  fcm_pkg::entry_t q [CACHE_DEPTH];
  fcm_pkg::entry_t head, upd, newe, ld_data, exp_d, pend;
  logic            shift, ld_en, exp_v, pend_v;
  logic [CW-1:0]   ld_pos;
  logic            expired, hit, upd_fin, new_fin;

  assign busy = (state != fcm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers; timeouts are kept as millisecond thresholds.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_thr <= 32'(fcm_pkg::ACTIVE_RESET_S) * 32'(fcm_pkg::MS_PER_S);
      ina_thr <= 32'(fcm_pkg::INACTIVE_RESET_S) * 32'(fcm_pkg::MS_PER_S);
      cache_limit <= fcm_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcm_pkg::REG_ACTIVE: begin
          act_thr <= 32'(cfg_data) * 32'(fcm_pkg::MS_PER_S);
        end
        fcm_pkg::REG_INACTIVE: begin
          ina_thr <= 32'(cfg_data) * 32'(fcm_pkg::MS_PER_S);
        end
        fcm_pkg::REG_LIMIT: begin
          cache_limit <= cfg_data[5:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The limit is used clamped to the range 1 to CACHE_DEPTH.
  always_comb begin
    if (cache_limit == 6'd0) begin
      lim = CW'(1);
    end else if (7'(cache_limit) > 7'(CACHE_DEPTH)) begin
      lim = CW'(CACHE_DEPTH);
    end else begin
      lim = CW'(cache_limit);
    end
  end

  // The chain: each cell takes its upper neighbor on a shift.
  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    fcm_pkg::cell_ctl_t ctl;
    assign ctl.shift = shift;
    assign ctl.load = ld_en && (ld_pos == CW'(i));
    fcm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_next (q[(i + 1 < CACHE_DEPTH) ? i + 1 : i]),
      .load_data (ld_data),
      .q         (q[i])
    );
  end

  assign head = q[0];

  always_comb begin
    expired = ((item_r.time_ms - head.first_ms) >= act_thr) ||
              ((item_r.time_ms - head.last_ms) >= ina_thr);
    hit = !found && (head.src_addr == item_r.src_addr) &&
          (head.dst_addr == item_r.dst_addr) &&
          (head.sport == item_r.src_port_in) &&
          (head.dport == item_r.dst_port_in) &&
          (head.proto == item_r.proto) && (head.tos == item_r.tos_in);
    upd = head;
    upd.packets = head.packets + 32'd1;
    upd.bytes = head.bytes + 32'(item_r.pkt_len);
    upd.flags = head.flags | item_r.flags_in;
    upd.last_ms = item_r.time_ms;
    upd_fin = upd.flags[fcm_pkg::FLAG_FIN_BIT] || item_r.flags_in[fcm_pkg::FLAG_RST_BIT];
    newe.src_addr = item_r.src_addr;
    newe.dst_addr = item_r.dst_addr;
    newe.sport = item_r.src_port_in;
    newe.dport = item_r.dst_port_in;
    newe.proto = item_r.proto;
    newe.tos = item_r.tos_in;
    newe.flags = item_r.flags_in;
    newe.packets = 32'd1;
    newe.bytes = 32'(item_r.pkt_len);
    newe.first_ms = item_r.time_ms;
    newe.last_ms = item_r.time_ms;
    new_fin = item_r.flags_in[fcm_pkg::FLAG_FIN_BIT] ||
              item_r.flags_in[fcm_pkg::FLAG_RST_BIT];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fcm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (item.op == fcm_pkg::OP_FLUSH) ? fcm_pkg::ST_FLUSH : fcm_pkg::ST_TMO;
        end
      end
      fcm_pkg::ST_TMO: begin
        if (rem == '0) state_next = fcm_pkg::ST_MATCH;
      end
      fcm_pkg::ST_MATCH: begin
        if (rem == '0) begin
          if (found) state_next = fcm_pkg::ST_DONE;
          else if (cnt >= lim) state_next = fcm_pkg::ST_EVICT;
          else state_next = fcm_pkg::ST_APPEND;
        end
      end
      fcm_pkg::ST_EVICT:  state_next = fcm_pkg::ST_APPEND;
      fcm_pkg::ST_APPEND: state_next = fcm_pkg::ST_DONE;
      fcm_pkg::ST_FLUSH: begin
        if (cnt == '0) state_next = fcm_pkg::ST_DONE;
      end
      fcm_pkg::ST_DONE:   state_next = fcm_pkg::ST_IDLE;
      default:            state_next = fcm_pkg::ST_IDLE;
    endcase
  end

  // Datapath control. Each step pops cell 0; a kept entry goes back at the
  // tail, which after the pop is position cnt - 1.
  always_comb begin
    shift = 1'b0;
    ld_en = 1'b0;
    ld_pos = cnt - CW'(1);
    ld_data = head;
    exp_v = 1'b0;
    exp_d = head;
    cnt_next = cnt;
    rem_next = rem;
    found_next = found;
    unique case (state)
      fcm_pkg::ST_IDLE: begin
        rem_next = cnt;
        found_next = 1'b0;
      end
      fcm_pkg::ST_TMO: begin
        if (rem != '0) begin
          shift = 1'b1;
          rem_next = rem - CW'(1);
          if (expired) begin
            exp_v = 1'b1;
            cnt_next = cnt - CW'(1);
          end else begin
            ld_en = 1'b1;
          end
        end else begin
          rem_next = cnt;
        end
      end
      fcm_pkg::ST_MATCH: begin
        if (rem != '0) begin
          shift = 1'b1;
          rem_next = rem - CW'(1);
          found_next = found || hit;
          if (hit && upd_fin) begin
            exp_v = 1'b1;
            exp_d = upd;
            cnt_next = cnt - CW'(1);
          end else begin
            ld_en = 1'b1;
            ld_data = hit ? upd : head;
          end
        end
      end
      fcm_pkg::ST_EVICT: begin
        shift = 1'b1;
        exp_v = 1'b1;
        cnt_next = cnt - CW'(1);
      end
      fcm_pkg::ST_APPEND: begin
        if (new_fin) begin
          exp_v = 1'b1;
          exp_d = newe;
        end else begin
          ld_en = 1'b1;
          ld_pos = cnt;
          ld_data = newe;
          cnt_next = cnt + CW'(1);
        end
      end
      fcm_pkg::ST_FLUSH: begin
        if (cnt != '0) begin
          shift = 1'b1;
          exp_v = 1'b1;
          cnt_next = cnt - CW'(1);
        end
      end
      fcm_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcm_pkg::ST_IDLE;
      cnt <= '0;
      rem <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      rem <= rem_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) item_r <= item;
  end

  // One exported entry is held back until the next export or the end of the
  // item shows whether it is the last word of the run.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_v <= 1'b0;
    end else if (exp_v) begin
      pend <= exp_d;
      pend_v <= 1'b1;
      result_valid <= pend_v;
      if (pend_v) begin
        result <= fcm_pkg::to_result(pend, 1'b0);
      end
    end else if (state == fcm_pkg::ST_DONE) begin
      result_valid <= pend_v;
      result <= fcm_pkg::to_result(pend, 1'b1);
      pend_v <= 1'b0;
    end else begin
      result_valid <= 1'b0;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CACHE_DEPTH)) else $error("flow count exceeds cache depth");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_of_run) |-> !busy)
    else $error("last word of a run while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == fcm_pkg::ST_IDLE) |-> !pend_v)
    else $error("held word left over while idle");

endmodule

/* tb/flow_cache_metering_test.sv */
// Self-checking testbench for the flow cache metering block.
`timescale 1ns / 100ps

module flow_cache_metering_test;

  localparam int DEPTH = 32;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  fcm_pkg::item_t item = '0;
  logic result_valid;
  fcm_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = fcm_pkg::REG_ACTIVE;
  logic [15:0] cfg_data = '0;

  flow_cache_metering #(.CACHE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the flow cache: register copies and the entries, oldest first.
  logic [15:0] active_s;
  logic [15:0] inactive_s;
  logic [5:0] limit_reg;
  fcm_pkg::entry_t flows [DEPTH];
  int flow_count;

  // Records the block should still export, in order.
  fcm_pkg::result_t pending_records [$];

  int errors = 0;
  int items_sent = 0;
  int records_seen = 0;
  int cfg_writes = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic fcm_pkg::result_t record_of(input fcm_pkg::entry_t e);
    fcm_pkg::result_t r;
    r.rec_src_addr = e.src_addr;
    r.rec_dst_addr = e.dst_addr;
    r.rec_src_port = e.sport;
    r.rec_dst_port = e.dport;
    r.rec_proto = e.proto;
    r.rec_tos = e.tos;
    r.rec_flags = e.flags;
    r.rec_packets = e.packets;
    r.rec_bytes = e.bytes;
    r.rec_first_ms = e.first_ms;
    r.rec_last_ms = e.last_ms;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Exports flow k and closes the gap behind it.
  function automatic void export_flow(input int k, ref fcm_pkg::result_t recs [$]);
    recs.insert(recs.size(), record_of(flows[k]));
    for (int j = k; j + 1 < flow_count; j++) flows[j] = flows[j + 1];
    flow_count--;
  endfunction

  // Works out the records that one accepted word causes and updates the mirror.
  function automatic void predict_exports(input fcm_pkg::item_t it,
                                          ref fcm_pkg::result_t recs [$]);
    logic [31:0] act_ms;
    logic [31:0] inact_ms;
    int e;
    int hit;
    int lim;
    recs = {};
    if (it.op == fcm_pkg::OP_FLUSH) begin
      while (flow_count > 0) export_flow(0, recs);
    end else begin
      act_ms = 32'(active_s) * fcm_pkg::MS_PER_S;
      inact_ms = 32'(inactive_s) * fcm_pkg::MS_PER_S;
      // Timeout sweep: the subtraction wraps just like the time stamps do.
      e = 0;
      while (e < flow_count) begin
        if (it.time_ms - flows[e].first_ms >= act_ms ||
            it.time_ms - flows[e].last_ms >= inact_ms)
          export_flow(e, recs);
        else
          e++;
      end
      hit = -1;
      for (int k = 0; k < flow_count; k++) begin
        if (hit < 0 && flows[k].src_addr == it.src_addr &&
            flows[k].dst_addr == it.dst_addr && flows[k].sport == it.src_port_in &&
            flows[k].dport == it.dst_port_in && flows[k].proto == it.proto &&
            flows[k].tos == it.tos_in)
          hit = k;
      end
      if (hit >= 0) begin
        flows[hit].packets += 1;
        flows[hit].bytes += 32'(it.pkt_len);
        flows[hit].flags |= it.flags_in;
        flows[hit].last_ms = it.time_ms;
      end else begin
        // The limit register is clamped into 1..DEPTH; only one flow is evicted
        // even when the limit was lowered below the current count.
        lim = int'(limit_reg);
        if (lim < 1) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        if (flow_count >= lim) export_flow(0, recs);
        hit = flow_count;
        flows[hit].src_addr = it.src_addr;
        flows[hit].dst_addr = it.dst_addr;
        flows[hit].sport = it.src_port_in;
        flows[hit].dport = it.dst_port_in;
        flows[hit].proto = it.proto;
        flows[hit].tos = it.tos_in;
        flows[hit].flags = it.flags_in;
        flows[hit].packets = 32'd1;
        flows[hit].bytes = 32'(it.pkt_len);
        flows[hit].first_ms = it.time_ms;
        flows[hit].last_ms = it.time_ms;
        flow_count++;
      end
      if (flows[hit].flags[fcm_pkg::FLAG_FIN_BIT] || it.flags_in[fcm_pkg::FLAG_RST_BIT])
        export_flow(hit, recs);
    end
    if (recs.size() > 0) recs[recs.size() - 1].last_of_run = 1'b1;
  endfunction

  // Hands one word to the block. Start stays high from the previous word when
  // there is no gap, so it never gets two assignments in one step.
  task automatic send_word(input fcm_pkg::item_t it, input int gap,
                           ref fcm_pkg::result_t recs [$]);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_exports(it, recs);
    foreach (recs[i]) pending_records.insert(pending_records.size(), recs[i]);
    items_sent++;
  endtask

  // Registers change only once the cache has gone quiet; an item that exports
  // nothing may still be scanning, hence the extra settle time.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    start <= 1'b0;
    while (pending_records.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fcm_pkg::REG_ACTIVE: active_s = val;
      fcm_pkg::REG_INACTIVE: inactive_s = val;
      fcm_pkg::REG_LIMIT: limit_reg = val[5:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Every strobed word is compared with the oldest expected record.
  always @(posedge clk) begin
    fcm_pkg::result_t want;
    if (!rst && result_valid) begin
      records_seen++;
      if (pending_records.size() == 0) begin
        report("record exported with none expected");
      end else begin
        want = pending_records[0];
        pending_records.delete(0);
        check_field("src_addr", result.rec_src_addr, want.rec_src_addr);
        check_field("dst_addr", result.rec_dst_addr, want.rec_dst_addr);
        check_field("src_port", 32'(result.rec_src_port), 32'(want.rec_src_port));
        check_field("dst_port", 32'(result.rec_dst_port), 32'(want.rec_dst_port));
        check_field("proto", 32'(result.rec_proto), 32'(want.rec_proto));
        check_field("tos", 32'(result.rec_tos), 32'(want.rec_tos));
        check_field("flags", 32'(result.rec_flags), 32'(want.rec_flags));
        check_field("packets", result.rec_packets, want.rec_packets);
        check_field("bytes", result.rec_bytes, want.rec_bytes);
        check_field("first_ms", result.rec_first_ms, want.rec_first_ms);
        check_field("last_ms", result.rec_last_ms, want.rec_last_ms);
        check_field("last_of_run", 32'(result.last_of_run), 32'(want.last_of_run));
      end
    end
  end

  function automatic fcm_pkg::item_t pkt(input logic [31:0] t, input logic [31:0] sa,
                                         input logic [31:0] da, input logic [15:0] sp,
                                         input logic [15:0] dp, input logic [7:0] pr,
                                         input logic [7:0] tos, input logic [7:0] fl,
                                         input logic [15:0] len);
    fcm_pkg::item_t it;
    it.op = fcm_pkg::OP_PACKET;
    it.time_ms = t;
    it.src_addr = sa;
    it.dst_addr = da;
    it.src_port_in = sp;
    it.dst_port_in = dp;
    it.proto = pr;
    it.tos_in = tos;
    it.flags_in = fl;
    it.pkt_len = len;
    return it;
  endfunction

  // A word with every field drawn at random.
  function automatic fcm_pkg::item_t random_fields();
    fcm_pkg::item_t it;
    it.op = 1'($urandom);
    it.time_ms = $urandom;
    it.src_addr = $urandom;
    it.dst_addr = $urandom;
    it.src_port_in = 16'($urandom);
    it.dst_port_in = 16'($urandom);
    it.proto = 8'($urandom);
    it.tos_in = 8'($urandom);
    it.flags_in = 8'($urandom);
    it.pkt_len = 16'($urandom);
    return it;
  endfunction

  typedef struct {
    fcm_pkg::item_t word;
    int known_n;   // typed record count, -1 where only the mirror decides
    fcm_pkg::result_t known_rec;
  } step_row_t;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Small pool of flow keys so that random packets hit cached flows often.
  fcm_pkg::item_t key_pool [12];
  logic [31:0] now_ms;

  function automatic fcm_pkg::item_t random_word();
    fcm_pkg::item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      it = random_fields();
      it.op = fcm_pkg::OP_FLUSH;
      return it;
    end
    if (r < 80) it = key_pool[$urandom_range(0, 11)];
    else it = random_fields();
    it.op = fcm_pkg::OP_PACKET;
    r = $urandom_range(0, 99);
    if (r < 85) now_ms += $urandom_range(0, 3000);
    else if (r < 95) now_ms += $urandom_range(5000, 80000);
    else now_ms += $urandom;
    it.time_ms = now_ms;
    r = $urandom_range(0, 99);
    if (r < 65) it.flags_in = 8'h00;
    else if (r < 90) it.flags_in = 8'($urandom) & 8'hFA;
    else it.flags_in = 8'($urandom);
    it.pkt_len = 16'($urandom);
    return it;
  endfunction

  initial begin
    step_row_t rows [$];
    fcm_pkg::result_t recs [$];
    fcm_pkg::result_t one;
    // Random phases: active s, inactive s, limit; the run starts at reset values.
    logic [15:0] phase_act [7];
    logic [15:0] phase_inact [7];
    logic [15:0] phase_lim [7];

    phase_act = '{16'd60, 16'd0, 16'd65535, 16'd2, 16'd65535, 16'd65535, 16'd5};
    phase_inact = '{16'd10, 16'd0, 16'd65535, 16'd1, 16'd65535, 16'd65535, 16'd3};
    phase_lim = '{16'd32, 16'd1, 16'd63, 16'd4, 16'd0, 16'd32, 16'd8};

    active_s = fcm_pkg::ACTIVE_RESET_S;
    inactive_s = fcm_pkg::INACTIVE_RESET_S;
    limit_reg = fcm_pkg::LIMIT_RESET;
    flow_count = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk at the reset settings.
    one = '0;
    rows.insert(rows.size(), '{'{op: fcm_pkg::OP_FLUSH, default: '0}, 0, one});
    one = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
            32'd1, 32'h0000_FFFF, 32'd100, 32'd100, 1'b1};
    rows.insert(rows.size(), '{pkt(100, '1, '1, '1, '1, '1, '1, 8'hFF, 16'hFFFF), 1, one});
    rows.insert(rows.size(), '{pkt(200, 0, 0, 0, 0, 0, 0, 8'h00, 16'h0000), 0, one});
    rows.insert(rows.size(), '{pkt(300, 0, 0, 0, 0, 0, 0, 8'h02, 16'd100), 0, one});
    rows.insert(rows.size(), '{pkt(400, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80,
                                   8'd6, 8'h10, 8'h10, 16'd40), 0, one});
    // FIN closes an established flow.
    rows.insert(rows.size(), '{pkt(500, 0, 0, 0, 0, 0, 0, 8'h01, 16'd40), -1, one});
    // Far later: the idle flow has run past its inactive timeout.
    rows.insert(rows.size(), '{pkt(20000, 32'hC0A8_0101, 32'h0808_0808, 16'd0, 16'h0800,
                                   8'd1, 8'h00, 8'h00, 16'd84), -1, one});
    // RST on a new flow exports it at once.
    rows.insert(rows.size(), '{pkt(20100, 32'h0102_0304, 32'h0506_0708, 16'd5, 16'd6,
                                   8'd17, 8'h2E, 8'h04, 16'd9), -1, one});
    // Time stamps wrap around 2^32.
    rows.insert(rows.size(), '{pkt(32'hFFFF_FFF0, 32'hAAAA_5555, 32'h5555_AAAA, 16'hA5A5,
                                   16'h5A5A, 8'd6, 8'h00, 8'h02, 16'd60), -1, one});
    rows.insert(rows.size(), '{pkt(32'h0000_0010, 32'hAAAA_5555, 32'h5555_AAAA, 16'hA5A5,
                                   16'h5A5A, 8'd6, 8'h00, 8'h10, 16'd60), -1, one});
    rows.insert(rows.size(), '{'{op: fcm_pkg::OP_FLUSH, default: '1}, -1, one});
    foreach (rows[i]) begin
      send_word(rows[i].word, pick_gap(), recs);
      if (rows[i].known_n >= 0 && recs.size() != rows[i].known_n)
        report($sformatf("directed row %0d: %0d records foreseen", i, recs.size()));
      if (rows[i].known_n == 1 && recs.size() == 1 && recs[0] != rows[i].known_rec)
        report($sformatf("directed row %0d: record differs from table", i));
    end

    // Zero timeouts expire every cached flow on the next packet.
    write_reg(fcm_pkg::REG_ACTIVE, 16'd0);
    write_reg(fcm_pkg::REG_INACTIVE, 16'd0);
    send_word(pkt(1000, 1, 2, 3, 4, 6, 0, 0, 10), 0, recs);
    send_word(pkt(1001, 5, 6, 7, 8, 6, 0, 0, 10), 0, recs);
    send_word('{op: fcm_pkg::OP_FLUSH, default: '0}, 0, recs);

    foreach (key_pool[i])
      key_pool[i] = random_fields();
    now_ms = $urandom;

    // Random phases; the cache carries over each change, so a lowered limit
    // meets a cache that is already fuller than it allows.
    foreach (phase_act[p]) begin
      write_reg(fcm_pkg::REG_ACTIVE, phase_act[p]);
      write_reg(fcm_pkg::REG_INACTIVE, phase_inact[p]);
      write_reg(fcm_pkg::REG_LIMIT, phase_lim[p]);
      repeat (34) send_word(random_word(), pick_gap(), recs);
    end
    send_word('{op: fcm_pkg::OP_FLUSH, default: '0}, pick_gap(), recs);
    start <= 1'b0;

    while (pending_records.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words over %0d register writes; %0d flow records checked.",
             items_sent, cfg_writes, records_seen);
    if (errors == 0) begin
      $display("flow_cache_metering regression: pass");
    end else begin
      $display("flow_cache_metering regression: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d records still expected.", pending_records.size());
    $display("flow_cache_metering regression: fail");
    $finish;
  end

endmodule
